// ----- rtl/button_debounce_setpoint_stepper_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce setpoint stepper
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_SETPOINT_STEPPER_DEFINES_SVH
`define BUTTON_DEBOUNCE_SETPOINT_STEPPER_DEFINES_SVH

`ifndef SYNTH

// check a property on every rising edge outside reset
`define BDSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check an implication from one cycle to the next outside reset
`define BDSS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`else

`define BDSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDSS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

// ----- rtl/bdss_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce setpoint stepper package
// Register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bdss_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_HOLD        = 3'd1;
  localparam logic [2:0] REG_REPEAT      = 3'd2;
  localparam logic [2:0] REG_STEP_SINGLE = 3'd3;
  localparam logic [2:0] REG_STEP_FAST   = 3'd4;
  localparam logic [2:0] REG_TARGET_MIN  = 3'd5;
  localparam logic [2:0] REG_TARGET_MAX  = 3'd6;

  localparam logic [15:0] RST_DEBOUNCE    = 16'd50;
  localparam logic [15:0] RST_HOLD        = 16'd1000;
  localparam logic [15:0] RST_REPEAT      = 16'd500;
  localparam logic [7:0]  RST_STEP_SINGLE = 8'd1;
  localparam logic [7:0]  RST_STEP_FAST   = 8'd5;
  localparam logic [7:0]  RST_TARGET_MIN  = 8'd40;
  localparam logic [7:0]  RST_TARGET_MAX  = 8'd70;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_ticks;
    logic [7:0]  step_single;
    logic [7:0]  step_fast;
    logic [7:0]  target_min;
    logic [7:0]  target_max;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/button_debounce_setpoint_stepper.sv -----
// ----------------------------------------------------------------------------
// Button debounce setpoint stepper
// Debounces a push button sampled once per millisecond tick and steps a
// setpoint on short presses, long presses and auto-repeat while held.
//
// Usage:
//   Input channel (in_valid/in_ready): one item per millisecond tick with
//   in_mode 0 and the raw active-low pin level, or a setpoint load with
//   in_mode 1 and in_new_target.
//   Result channel (out_valid/out_ready): exactly one result per item, the
//   setpoint after the item, whether the button changed it on this tick and
//   the debounced button state.
//   The result of an item accepted at one edge is offered from the next
//   cycle. Throughput is one item per cycle while the receiver takes results;
//   the whole update is a single pass of counter, compare and two chained add/wrap
//   stages between the state registers and the output register.
//   A stalled receiver holds the result in the output register; a new item
//   is still taken in the cycle the held result leaves.
//   Reset (rst_n low, synchronous) clears all counters, the debounce and
//   press state and the setpoint, and restores the register defaults.
//   Registers are written through the APB-style port at byte address 4*i.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_setpoint_stepper_defines.svh"

module button_debounce_setpoint_stepper #(
  parameter int COUNT_WIDTH = 16,
  parameter int TEMP_WIDTH  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bdss_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bdss_pkg::DATA_W-1:0]   pwdata,
  output logic      [bdss_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_mode,
  input  wire logic                          in_pin_level,
  input  wire logic [7:0]                    in_new_target,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [7:0]                    out_target,
  output logic                               out_changed,
  output logic                               out_pressed
);

  localparam int CW    = COUNT_WIDTH;
  localparam int TW    = TEMP_WIDTH;
  localparam int CMP_W = (CW > 16) ? CW : 16;
  localparam int SUM_W = ((TW > 8) ? TW : 8) + 1;

  bdss_pkg::cfg_t cfg;

  logic          raw_prev_r, raw_prev_nxt;
  logic [CW-1:0] stable_r, stable_nxt;
  logic          deb_r, deb_nxt;
  logic [CW-1:0] press_r, press_nxt;
  logic          held_r, held_nxt;
  logic          fast_r, fast_nxt;
  logic [CW-1:0] rep_r, rep_nxt;
  logic [TW-1:0] sp_r, sp_nxt;
  logic          changed_nxt;

  logic          out_valid_r;
  logic [7:0]    out_target_r;
  logic          out_changed_r;
  logic          out_pressed_r;

  logic          in_xfer;
  logic          raw;
  logic          edge_det;

  bdss_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  function automatic logic [TW-1:0] add_step(input logic [TW-1:0] sp,
                                             input logic [7:0] step,
                                             input logic [7:0] tmin,
                                             input logic [7:0] tmax);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(sp) + SUM_W'(step);
    if (sum > SUM_W'(tmax)) begin
      sum = SUM_W'(tmin);
    end
    add_step = sum[TW-1:0];
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign raw      = ~in_pin_level;

  always_comb begin
    raw_prev_nxt = raw_prev_r;
    stable_nxt   = stable_r;
    deb_nxt      = deb_r;
    press_nxt    = press_r;
    held_nxt     = held_r;
    fast_nxt     = fast_r;
    rep_nxt      = rep_r;
    sp_nxt       = sp_r;
    changed_nxt  = 1'b0;
    edge_det     = 1'b0;
    if (in_mode) begin
      sp_nxt = TW'(in_new_target);
    end else begin
      if (held_r && deb_r) begin
        press_nxt = sat_inc(press_r);
        if (fast_r) begin
          rep_nxt = sat_inc(rep_r);
        end
      end
      if (raw != raw_prev_r) begin
        raw_prev_nxt = raw;
        stable_nxt   = '0;
      end else begin
        stable_nxt = sat_inc(stable_r);
      end
      edge_det = (CMP_W'(stable_nxt) >= CMP_W'(cfg.debounce_ticks)) && (deb_r != raw);
      if (edge_det) begin
        deb_nxt = raw;
      end
      if (edge_det && raw) begin
        held_nxt  = 1'b1;
        fast_nxt  = 1'b0;
        press_nxt = '0;
      end else begin
        if (edge_det) begin
          held_nxt = 1'b0;
          fast_nxt = 1'b0;
          if (CMP_W'(press_nxt) < CMP_W'(cfg.hold_ticks)) begin
            sp_nxt      = add_step(sp_nxt, cfg.step_single, cfg.target_min, cfg.target_max);
            changed_nxt = 1'b1;
          end else if (!fast_r) begin
            sp_nxt      = add_step(sp_nxt, cfg.step_fast, cfg.target_min, cfg.target_max);
            changed_nxt = 1'b1;
          end
        end
        if (deb_nxt && held_nxt && (CMP_W'(press_nxt) >= CMP_W'(cfg.hold_ticks))) begin
          if (!fast_nxt) begin
            fast_nxt    = 1'b1;
            rep_nxt     = '0;
            sp_nxt      = add_step(sp_nxt, cfg.step_fast, cfg.target_min, cfg.target_max);
            changed_nxt = 1'b1;
          end
          if (CMP_W'(rep_nxt) >= CMP_W'(cfg.repeat_ticks)) begin
            rep_nxt     = '0;
            sp_nxt      = add_step(sp_nxt, cfg.step_fast, cfg.target_min, cfg.target_max);
            changed_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r <= 1'b0;
      stable_r   <= '0;
      deb_r      <= 1'b0;
      press_r    <= '0;
      held_r     <= 1'b0;
      fast_r     <= 1'b0;
      rep_r      <= '0;
      sp_r       <= '0;
    end else if (in_xfer) begin
      raw_prev_r <= raw_prev_nxt;
      stable_r   <= stable_nxt;
      deb_r      <= deb_nxt;
      press_r    <= press_nxt;
      held_r     <= held_nxt;
      fast_r     <= fast_nxt;
      rep_r      <= rep_nxt;
      sp_r       <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_target_r  <= 8'(sp_nxt);
      out_changed_r <= changed_nxt;
      out_pressed_r <= deb_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_target  = out_target_r;
  assign out_changed = out_changed_r;
  assign out_pressed = out_pressed_r;

  `BDSS_ASSERT(a_fast_needs_held, clk, rst_n, fast_r |-> held_r, "fast mode without a held press")
  `BDSS_ASSERT(a_held_needs_pressed, clk, rst_n, held_r |-> deb_r, "held press while released")
  `BDSS_ASSERT_NEXT(a_load_no_change, clk, rst_n, in_xfer && in_mode, !out_changed_r, "load transfer flagged a change")
  `BDSS_ASSERT_NEXT(a_load_keeps_debounce, clk, rst_n, in_xfer && in_mode, deb_r == $past(deb_r), "load transfer moved debounce state")

endmodule

`default_nettype wire

// ----- rtl/bdss_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write and read of the seven timing, step and target-range registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdss_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bdss_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bdss_pkg::DATA_W-1:0]   pwdata,
  output logic      [bdss_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output bdss_pkg::cfg_t                     cfg
);

  bdss_pkg::cfg_t cfg_r;
  bdss_pkg::cfg_t cfg_nxt;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        bdss_pkg::REG_DEBOUNCE:    cfg_nxt.debounce_ticks = pwdata[15:0];
        bdss_pkg::REG_HOLD:        cfg_nxt.hold_ticks     = pwdata[15:0];
        bdss_pkg::REG_REPEAT:      cfg_nxt.repeat_ticks   = pwdata[15:0];
        bdss_pkg::REG_STEP_SINGLE: cfg_nxt.step_single    = pwdata[7:0];
        bdss_pkg::REG_STEP_FAST:   cfg_nxt.step_fast      = pwdata[7:0];
        bdss_pkg::REG_TARGET_MIN:  cfg_nxt.target_min     = pwdata[7:0];
        bdss_pkg::REG_TARGET_MAX:  cfg_nxt.target_max     = pwdata[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bdss_pkg::REG_DEBOUNCE:    prdata = 32'(cfg_r.debounce_ticks);
      bdss_pkg::REG_HOLD:        prdata = 32'(cfg_r.hold_ticks);
      bdss_pkg::REG_REPEAT:      prdata = 32'(cfg_r.repeat_ticks);
      bdss_pkg::REG_STEP_SINGLE: prdata = 32'(cfg_r.step_single);
      bdss_pkg::REG_STEP_FAST:   prdata = 32'(cfg_r.step_fast);
      bdss_pkg::REG_TARGET_MIN:  prdata = 32'(cfg_r.target_min);
      bdss_pkg::REG_TARGET_MAX:  prdata = 32'(cfg_r.target_max);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= bdss_pkg::RST_DEBOUNCE;
      cfg_r.hold_ticks     <= bdss_pkg::RST_HOLD;
      cfg_r.repeat_ticks   <= bdss_pkg::RST_REPEAT;
      cfg_r.step_single    <= bdss_pkg::RST_STEP_SINGLE;
      cfg_r.step_fast      <= bdss_pkg::RST_STEP_FAST;
      cfg_r.target_min     <= bdss_pkg::RST_TARGET_MIN;
      cfg_r.target_max     <= bdss_pkg::RST_TARGET_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Button debounce setpoint stepper testbench
// Feeds millisecond ticks and setpoint loads through the input channel and
// checks every result against a cycle-free model of the debounce, long-press
// and auto-repeat rules. The register port sweeps several settings, the
// extremes among them, the largest register values included.
// ----------------------------------------------------------------------------
module tb;

  localparam int          COUNT_W     = 16;
  localparam int unsigned CNT_MAX     = (1 << COUNT_W) - 1;
  localparam int          STALL_LIMIT = 4000;
  localparam bit          PIN_PRESSED  = 1'b0;
  localparam bit          PIN_RELEASED = 1'b1;

  typedef enum bit {ITEM_TICK = 1'b0, ITEM_LOAD = 1'b1} item_kind_t;

  typedef struct packed {
    logic [7:0] target;
    logic       changed;
    logic       pressed;
  } stepper_result_t;

  class setpoint_scoreboard;
    int unsigned debounce_ticks, hold_ticks, repeat_ticks;
    bit [7:0]    step_single, step_fast, target_min, target_max;

    bit          raw_prev, debounced, held, fast_mode;
    int unsigned stable_count, press_count, repeat_count;
    bit [7:0]    setpoint;

    stepper_result_t expected_q[$];
    int unsigned n_checked, n_errors, n_changes, n_fast_entries;

    function new();
      debounce_ticks = bdss_pkg::RST_DEBOUNCE;
      hold_ticks     = bdss_pkg::RST_HOLD;
      repeat_ticks   = bdss_pkg::RST_REPEAT;
      step_single    = bdss_pkg::RST_STEP_SINGLE;
      step_fast      = bdss_pkg::RST_STEP_FAST;
      target_min     = bdss_pkg::RST_TARGET_MIN;
      target_max     = bdss_pkg::RST_TARGET_MAX;
      raw_prev       = 1'b0;
      debounced      = 1'b0;
      held           = 1'b0;
      fast_mode      = 1'b0;
      stable_count   = 0;
      press_count    = 0;
      repeat_count   = 0;
      setpoint       = 8'd0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        bdss_pkg::REG_DEBOUNCE:    debounce_ticks = value[15:0];
        bdss_pkg::REG_HOLD:        hold_ticks     = value[15:0];
        bdss_pkg::REG_REPEAT:      repeat_ticks   = value[15:0];
        bdss_pkg::REG_STEP_SINGLE: step_single    = value[7:0];
        bdss_pkg::REG_STEP_FAST:   step_fast      = value[7:0];
        bdss_pkg::REG_TARGET_MIN:  target_min     = value[7:0];
        bdss_pkg::REG_TARGET_MAX:  target_max     = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    function void add_step(bit [7:0] step);
      int unsigned sum;
      sum = int'(setpoint) + int'(step);
      if (sum > target_max) sum = target_min;
      setpoint = sum[7:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(item_kind_t kind, bit pin, bit [7:0] new_target);
      bit raw, accepted, was_fast, chg;
      chg = 1'b0;
      if (kind == ITEM_LOAD) begin
        setpoint = new_target;
      end else begin
        raw = ~pin;
        accepted = 1'b0;
        if (held && debounced) begin
          press_count = bump(press_count);
          if (fast_mode) repeat_count = bump(repeat_count);
        end
        if (raw != raw_prev) begin
          raw_prev = raw;
          stable_count = 0;
        end else begin
          stable_count = bump(stable_count);
        end
        if (stable_count >= debounce_ticks && debounced != raw) begin
          debounced = raw;
          accepted = 1'b1;
        end
        if (accepted && debounced) begin
          held = 1'b1;
          fast_mode = 1'b0;
          press_count = 0;
        end else begin
          if (accepted) begin
            was_fast = fast_mode;
            held = 1'b0;
            fast_mode = 1'b0;
            if (press_count < hold_ticks) begin
              add_step(step_single);
              chg = 1'b1;
            end else if (!was_fast) begin
              add_step(step_fast);
              chg = 1'b1;
            end
          end
          if (debounced && held && press_count >= hold_ticks) begin
            if (!fast_mode) begin
              fast_mode = 1'b1;
              repeat_count = 0;
              add_step(step_fast);
              chg = 1'b1;
              n_fast_entries++;
            end
            if (repeat_count >= repeat_ticks) begin
              repeat_count = 0;
              add_step(step_fast);
              chg = 1'b1;
            end
          end
        end
      end
      if (chg) n_changes++;
      expected_q.push_back('{target: setpoint, changed: chg, pressed: debounced});
    endfunction

    function void flag(string what, int want, int got);
      n_errors++;
      if (n_errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [7:0] target, logic changed, logic pressed);
      stepper_result_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %0d/%0b/%0b",
                 $time, target, changed, pressed);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (target !== want.target)   flag("target", want.target, target);
      if (changed !== want.changed) flag("changed", want.changed, changed);
      if (pressed !== want.pressed) flag("pressed", want.pressed, pressed);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [bdss_pkg::ADDR_W-1:0] paddr = '0;
  logic [bdss_pkg::DATA_W-1:0] pwdata = '0;
  logic [bdss_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_mode = 1'b0;
  logic                        in_pin_level = 1'b1;
  logic [7:0]                  in_new_target = 8'd0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_target;
  logic                        out_changed;
  logic                        out_pressed;

  setpoint_scoreboard sb = new();
  bit                 no_idle = 1'b0;
  int unsigned        items_sent = 0;
  int unsigned        n_settings = 0;
  int unsigned        quiet_cycles = 0;

  button_debounce_setpoint_stepper dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_pin_level (in_pin_level),
    .in_new_target(in_new_target),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_target   (out_target),
    .out_changed  (out_changed),
    .out_pressed  (out_pressed)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_target, out_changed, out_pressed);
      if (in_valid && in_ready)
        sb.note_item(item_kind_t'(in_mode), in_pin_level, in_new_target);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(input item_kind_t kind, input bit pin, input bit [7:0] new_target);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= kind;
    in_pin_level  <= pin;
    in_new_target <= new_target;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic load_target(input bit [7:0] value);
    send_item(ITEM_LOAD, 1'($urandom_range(0, 1)), value);
  endtask

  task automatic hold_pin(input bit pin, input int unsigned n);
    repeat (n) send_item(ITEM_TICK, pin, 8'($urandom));
  endtask

  task automatic rattle(input int unsigned n);
    repeat (n) send_item(ITEM_TICK, 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper bits carry junk that the block must drop
  task automatic configure(input bit [15:0] dbn, input bit [15:0] hold, input bit [15:0] rpt,
                           input bit [7:0] ss, input bit [7:0] sf,
                           input bit [7:0] lo, input bit [7:0] hi);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(bdss_pkg::REG_DEBOUNCE,    {junk[31:16], dbn});
    write_reg(bdss_pkg::REG_HOLD,        {junk[15:0], hold});
    write_reg(bdss_pkg::REG_REPEAT,      {junk[23:8], rpt});
    write_reg(bdss_pkg::REG_STEP_SINGLE, {junk[31:8], ss});
    write_reg(bdss_pkg::REG_STEP_FAST,   {junk[23:0], sf});
    write_reg(bdss_pkg::REG_TARGET_MIN,  {junk[27:4], lo});
    write_reg(bdss_pkg::REG_TARGET_MAX,  {junk[30:7], hi});
    n_settings++;
  endtask

  function automatic bit [7:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(1, 20));
  endfunction

  task automatic random_setting();
    bit [7:0] lo, hi;
    if ($urandom_range(0, 4) == 0) begin
      lo = 8'($urandom);
      hi = 8'($urandom);
    end else begin
      lo = 8'($urandom_range(0, 200));
      hi = 8'(lo + $urandom_range(0, 55));
    end
    configure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 25)),
              16'($urandom_range(0, 8)), pick_step(), pick_step(), lo, hi);
  endtask

  // mostly clean press and release episodes, with loads and bounce mixed in
  task automatic random_traffic(input int unsigned n_items);
    int unsigned stop_at, sel, span;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        load_target(8'($urandom));
      end else if (sel < 20) begin
        rattle($urandom_range(1, 6));
      end else begin
        rattle($urandom_range(0, 3));
        span = sb.hold_ticks + 3 * sb.repeat_ticks + sb.debounce_ticks + 6;
        if (span > 120) span = 120;
        repeat ($urandom_range(0, span)) begin
          if ($urandom_range(0, 99) < 3) load_target(8'($urandom));
          else hold_pin(PIN_PRESSED, 1);
        end
        rattle($urandom_range(0, 3));
        hold_pin(PIN_RELEASED, $urandom_range(sb.debounce_ticks, sb.debounce_ticks + 6));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: loads at both ends, debounce holds off a short press
    load_target(8'd255);
    load_target(8'd0);
    hold_pin(PIN_PRESSED, 1);
    hold_pin(PIN_RELEASED, 1);
    settle();

    // no debounce, no hold, no repeat interval, wrap with minimum above maximum
    configure(16'd0, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    hold_pin(PIN_PRESSED, 3);
    hold_pin(PIN_RELEASED, 1);
    hold_pin(PIN_PRESSED, 1);
    hold_pin(PIN_RELEASED, 1);
    settle();

    // bounce, a press released on reaching the hold count, then a long press into fast repeat with wrap
    configure(16'd2, 16'd4, 16'd2, 8'd1, 8'd5, 8'd40, 8'd70);
    load_target(8'd69);
    hold_pin(PIN_PRESSED, 1);
    hold_pin(PIN_RELEASED, 1);
    hold_pin(PIN_PRESSED, 4);
    hold_pin(PIN_RELEASED, 3);
    hold_pin(PIN_PRESSED, 10);
    hold_pin(PIN_RELEASED, 3);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      random_setting();
      no_idle = (phase == 3);
      random_traffic(200);
      settle();
    end

    // largest register values: a press far too short to be accepted
    no_idle = 1'b1;
    configure(16'd0, 16'd5, 16'd5, 8'd1, 8'd3, 8'd0, 8'd255);
    hold_pin(PIN_RELEASED, 4);
    settle();
    configure(16'hFFFF, 16'hFFFF, 16'd900, 8'd1, 8'd3, 8'd0, 8'd255);
    hold_pin(PIN_PRESSED, 40);
    settle();
    configure(16'd0, 16'hFFFF, 16'hFFFF, 8'd1, 8'd3, 8'd0, 8'd255);
    hold_pin(PIN_RELEASED, 3);
    no_idle = 1'b0;
    random_traffic(30);

    settle();
    repeat (5) @(posedge clk);
    $display("summary: %0d items under %0d register settings, %0d results checked",
             items_sent, n_settings, sb.n_checked);
    $display("summary: %0d button-driven setpoint changes, %0d entries into fast repeat",
             sb.n_changes, sb.n_fast_entries);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
